>>> design/ure_pkg.sv
// ----------------------------------------------------------------------------
// ure_pkg: shared types and constants for the echo range display core
// Result record, scale constants, display codes and the BCD adjust step.
// ----------------------------------------------------------------------------
package ure_pkg;

	localparam int STAMP_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int Q_BITS         = 16;
	localparam int K_BITS         = 17;
	localparam int RANGE_BITS     = 14;
	localparam int BCD_BITS       = 16;

	localparam logic [15:0]           TICKS_RESET = 16'd16;
	// x1.715 and x0.675197 in Q16, rounded to nearest
	localparam logic [K_BITS-1:0]     CM_Q16      = 17'd112394;
	localparam logic [K_BITS-1:0]     IN_Q16      = 17'd44250;
	localparam logic [RANGE_BITS-1:0] RANGE_MAX   = 14'd9999;
	localparam logic [RANGE_BITS-1:0] TENS_MIN    = 14'd1000;
	localparam logic [3:0]            BLANK_DIGIT = 4'd15;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_hundredths;
		logic                  in_inches;
		logic                  saturated;
		logic [3:0]            digit_tens;
		logic [3:0]            digit_ones;
		logic [3:0]            digit_tenths;
		logic [3:0]            digit_hundredths;
	} result_t;

	// double-dabble: add 3 to every nibble that is 5 or more
	function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] b);
		logic [BCD_BITS-1:0] r;
		r = b;
		for (int i = 0; i < BCD_BITS / 4; i++) begin
			if (b[i*4 +: 4] >= 4'd5)
				r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
		end
		return r;
	endfunction

endpackage

>>> design/ure_fifo.sv
// ----------------------------------------------------------------------------
// ure_fifo: small register queue
// Holds measured jobs between the front and the back of the core.
// ----------------------------------------------------------------------------
module ure_fifo #(
	parameter int WIDTH = 33,
	parameter int DEPTH = ure_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             is_full,
	output logic             is_empty
);
	import ure_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> design/ure_front.sv
// ----------------------------------------------------------------------------
// ure_front: event intake
// Tracks the rise stamp and unit, turns falling edges into width jobs.
// ----------------------------------------------------------------------------
module ure_front #(
	parameter int STAMP_BITS = ure_pkg::STAMP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic                action,
	input  logic                echo_level,
	input  logic [31:0]         timer_stamp,
	output logic                full,
	output logic                job_push,
	output logic [STAMP_BITS:0] job_data
);
	import ure_pkg::*;

	logic [STAMP_BITS-1:0] rise_stamp_q;
	logic                  unit_inches_q;
	logic [STAMP_BITS-1:0] stamp;
	logic                  take;

	assign full     = q_full;
	assign take     = push && !q_full;
	assign stamp    = timer_stamp[STAMP_BITS-1:0];
	assign job_push = take && !action && !echo_level;
	// width wraps naturally in STAMP_BITS
	assign job_data = {unit_inches_q, stamp - rise_stamp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q  <= '0;
			unit_inches_q <= 1'b0;
		end else if (take) begin
			if (action)
				unit_inches_q <= !unit_inches_q;
			else if (echo_level)
				rise_stamp_q <= stamp;
		end
	end

endmodule

>>> design/ure_back.sv
// ----------------------------------------------------------------------------
// ure_back: range computation
// Serial divide, Q16 scale, saturate, serial BCD split, result register.
// ----------------------------------------------------------------------------
module ure_back #(
	parameter int STAMP_BITS = ure_pkg::STAMP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         ticks_per_us,
	input  logic                q_empty,
	input  logic [STAMP_BITS:0] job_data,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output ure_pkg::result_t    result
);
	import ure_pkg::*;

	localparam int SB     = STAMP_BITS;
	localparam int CNT_W  = $clog2(SB + 1);
	localparam int PROD_W = SB + K_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_BCD   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  unit_q;
	logic [15:0]           rem_q;
	logic [SB-1:0]         quo_q;
	logic [PROD_W-1:0]     prod_q;
	logic [RANGE_BITS-1:0] val_q;
	logic                  sat_q;
	logic [RANGE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	result_t               out_q;
	logic                  out_valid_q;

	logic [16:0]           trial;
	logic                  ge;
	logic [16:0]           diff;
	logic [SB:0]           scaled;
	logic                  over;
	logic [BCD_BITS-1:0]   bcd_adj;

	assign trial   = {rem_q, quo_q[SB-1]};
	assign ge      = (trial >= {1'b0, ticks_per_us});
	assign diff    = trial - {1'b0, ticks_per_us};
	assign scaled  = prod_q[PROD_W-1:Q_BITS];
	assign over    = (scaled > (SB + 1)'(RANGE_MAX));
	assign bcd_adj = bcd_adjust(bcd_q);

	assign job_pop = (state_q == ST_IDLE) && !q_empty;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			unit_q      <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			prod_q      <= '0;
			val_q       <= '0;
			sat_q       <= 1'b0;
			bin_q       <= '0;
			bcd_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						unit_q <= job_data[SB];
						rem_q  <= '0;
						cnt_q  <= CNT_W'(SB);
						// zero divisor: all-ones quotient
						if (ticks_per_us == '0) begin
							quo_q   <= '1;
							state_q <= ST_MUL;
						end else begin
							quo_q   <= job_data[SB-1:0];
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? diff[15:0] : trial[15:0];
					quo_q <= {quo_q[SB-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(quo_q) * PROD_W'(unit_q ? IN_Q16 : CM_Q16);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					val_q   <= over ? RANGE_MAX : scaled[RANGE_BITS-1:0];
					bin_q   <= over ? RANGE_MAX : scaled[RANGE_BITS-1:0];
					sat_q   <= over;
					bcd_q   <= '0;
					cnt_q   <= CNT_W'(RANGE_BITS);
					state_q <= ST_BCD;
				end
				ST_BCD: begin
					{bcd_q, bin_q} <= {bcd_adj[BCD_BITS-2:0], bin_q, 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// wait for the result register to drain
					if (!out_valid_q) begin
						out_q.range_hundredths <= val_q;
						out_q.in_inches        <= unit_q;
						out_q.saturated        <= sat_q;
						out_q.digit_tens       <= (val_q < TENS_MIN) ? BLANK_DIGIT
						                                             : bcd_q[15:12];
						out_q.digit_ones       <= bcd_q[11:8];
						out_q.digit_tenths     <= bcd_q[7:4];
						out_q.digit_hundredths <= bcd_q[3:0];
						out_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_range_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.range_hundredths <= RANGE_MAX)
		else $error("range above cap");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.saturated |-> out_q.range_hundredths == RANGE_MAX)
		else $error("saturated beat without capped value");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.digit_tens == BLANK_DIGIT)
		                 == (out_q.range_hundredths < TENS_MIN)))
		else $error("leading digit blanking wrong");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divider step count underflow");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished result not loaded");

endmodule

>>> design/ultrasonic_echo_range_display_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_display_core: echo pulse width to display digits
// Front event intake, job queue, and serial range computation back end.
// ----------------------------------------------------------------------------
// A falling echo edge yields one result beat once the back end picks it up:
// the pickup, one cycle per quotient bit in the restoring divider, one
// multiply, one scale/saturate, 14 double-dabble steps and the load of the
// result register follow in that order. A zero divisor skips the divider.
// The pickup comes in the cycle after the edge is accepted when the back end
// is idle. Rising edges and unit toggles are absorbed by the front and give
// no beat. A two-entry job queue lets the front take events while the back
// end is busy, and the result register lets the back end start the next job
// while a beat waits to be popped. ticks_per_us is written over the cfg
// channel, always ready. The user must write it only while the core is idle;
// the block itself does not enforce this.
module ultrasonic_echo_range_display_core #(
	parameter int STAMP_BITS = ure_pkg::STAMP_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic        echo_level,
	input  logic [31:0] timer_stamp,
	output logic        empty,
	input  logic        pop,
	output logic [13:0] range_hundredths,
	output logic        in_inches,
	output logic        saturated,
	output logic [3:0]  digit_tens,
	output logic [3:0]  digit_ones,
	output logic [3:0]  digit_tenths,
	output logic [3:0]  digit_hundredths
);
	import ure_pkg::*;

	logic [15:0]         ticks_q;
	logic                q_full;
	logic                q_empty;
	logic                job_push;
	logic                job_pop;
	logic [STAMP_BITS:0] job_in;
	logic [STAMP_BITS:0] job_out;
	result_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ticks_q <= TICKS_RESET;
		else if (cfg_valid && cfg_ready)
			ticks_q <= cfg_data;
	end

	ure_front #(.STAMP_BITS(STAMP_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (q_full),
		.action      (action),
		.echo_level  (echo_level),
		.timer_stamp (timer_stamp),
		.full        (full),
		.job_push    (job_push),
		.job_data    (job_in)
	);

	ure_fifo #(.WIDTH(STAMP_BITS + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_data  (job_in),
		.rd_en    (job_pop),
		.rd_data  (job_out),
		.is_full  (q_full),
		.is_empty (q_empty)
	);

	ure_back #(.STAMP_BITS(STAMP_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ticks_per_us (ticks_q),
		.q_empty      (q_empty),
		.job_data     (job_out),
		.job_pop      (job_pop),
		.pop          (pop),
		.empty        (empty),
		.result       (res)
	);

	assign range_hundredths = res.range_hundredths;
	assign in_inches        = res.in_inches;
	assign saturated        = res.saturated;
	assign digit_tens       = res.digit_tens;
	assign digit_ones       = res.digit_ones;
	assign digit_tenths     = res.digit_tenths;
	assign digit_hundredths = res.digit_hundredths;

endmodule
